@@ design/tsm_pkg.sv @@
// tsm_pkg: shared types, codes and helpers for the two-way sorted merge unit
// no dependencies; imported by tsm_ram users and the top level
package tsm_pkg;

  localparam int BUF_DEPTH_DEF = 32;
  localparam int WORD_W        = 32;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;

  // input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_A  = 2'd0,
    CMD_PUSH_B  = 2'd1,
    CMD_CLOSE_A = 2'd2,
    CMD_CLOSE_B = 2'd3
  } cmd_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ELEM = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_END  = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CMD    = 4'b0010,
    S_READ   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  // true while the merge loop still has a result to give
  function automatic logic merge_go(input logic a_nz, input logic b_nz,
                                    input logic a_cl, input logic b_cl,
                                    input logic fin);
    merge_go = (a_nz && b_nz) || (a_nz && b_cl) || (b_nz && a_cl) ||
               (!a_nz && !b_nz && a_cl && b_cl && !fin);
  endfunction

endpackage

@@ design/tsm_ram.sv @@
// tsm_ram: generic single-write, single-read ram with registered read data
// no package dependencies
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/two_way_sorted_merge_unit.sv @@
// two_way_sorted_merge_unit: merges two ascending word streams held in two rams
// depends on tsm_pkg and tsm_ram
//
// Each input transfer either pushes a word into side A or B or closes a side.
// After the command is applied the unit emits every merged word it can: the
// smaller head of the two buffers while both hold words (B wins a tie), one
// side straight through once the other is closed and empty, and a single end
// marker once both sides are closed and empty. A push into a full or closed
// side is dropped and reported as an overflow result. The last result caused
// by a transfer carries out_run_last. A transfer is taken only when the
// sequencer is idle; the command is then applied in the command state (an
// overflow result goes out there once the output slot is free), and every
// merged word or end marker then passes through a read state, which reads
// both buffer heads from the rams, and a decide state, which compares and
// pops once the output slot is free. The single-entry output register lets
// the next transfer be accepted while a result still waits downstream.
module two_way_sorted_merge_unit #(
  parameter int BUF_DEPTH = tsm_pkg::BUF_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tsm_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tsm_pkg::WORD_W-1:0]    in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsm_pkg::WORD_W-1:0]    out_merged_word,
  output logic [tsm_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_run_last
);
  import tsm_pkg::*;

  localparam int PTR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUF_DEPTH);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(BUF_DEPTH - 1);
  localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(BUF_DEPTH);

  // sequencer and latched command
  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;

  // buffer bookkeeping
  logic [CNT_W-1:0]    fill_a_r, fill_a_nxt, fill_b_r, fill_b_nxt;
  logic [PTR_W-1:0]    head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic                closed_a_r, closed_a_nxt, closed_b_r, closed_b_nxt;
  logic                fin_r, fin_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  // ram ports
  logic                we_a, we_b;
  logic [PTR_W-1:0]    waddr_a, waddr_b;
  logic [WORD_W-1:0]   head_val_a, head_val_b;

  // tail address = head + fill, wrapped once
  logic [CNT_W:0]      tail_sum_a, tail_sum_b, tail_a, tail_b;

  logic                slot_free;
  logic                a_nz, b_nz;
  logic                pop_a, pop_b;

  assign slot_free = !out_valid_r || out_ready;
  assign a_nz      = (fill_a_r != '0);
  assign b_nz      = (fill_b_r != '0);

  assign tail_sum_a = (CNT_W + 1)'(head_a_r) + (CNT_W + 1)'(fill_a_r);
  assign tail_sum_b = (CNT_W + 1)'(head_b_r) + (CNT_W + 1)'(fill_b_r);
  assign tail_a     = (tail_sum_a >= DEPTH_X) ? tail_sum_a - DEPTH_X : tail_sum_a;
  assign tail_b     = (tail_sum_b >= DEPTH_X) ? tail_sum_b - DEPTH_X : tail_sum_b;
  assign waddr_a    = tail_a[PTR_W-1:0];
  assign waddr_b    = tail_b[PTR_W-1:0];

  // the rams always read at the current heads; data is registered and valid in the following cycle
  tsm_ram #(.WIDTH(WORD_W), .DEPTH(BUF_DEPTH)) u_buf_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (word_r),
    .raddr (head_a_r),
    .rdata (head_val_a)
  );

  tsm_ram #(.WIDTH(WORD_W), .DEPTH(BUF_DEPTH)) u_buf_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (word_r),
    .raddr (head_b_r),
    .rdata (head_val_b)
  );

  // pop choice in the decide state: smaller head, tie goes to b
  always_comb begin
    pop_a = 1'b0;
    pop_b = 1'b0;
    if (a_nz && b_nz) begin
      pop_a = (head_val_a < head_val_b);
      pop_b = !(head_val_a < head_val_b);
    end else if (a_nz && closed_b_r) begin
      pop_a = 1'b1;
    end else if (b_nz && closed_a_r) begin
      pop_b = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    word_nxt       = word_r;
    fill_a_nxt     = fill_a_r;
    fill_b_nxt     = fill_b_r;
    head_a_nxt     = head_a_r;
    head_b_nxt     = head_b_r;
    closed_a_nxt   = closed_a_r;
    closed_b_nxt   = closed_b_r;
    fin_nxt        = fin_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    we_a           = 1'b0;
    we_b           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          word_nxt  = in_word;
          state_nxt = S_CMD;
        end
      end

      S_CMD: begin
        case (cmd_r)
          CMD_PUSH_A: begin
            if (closed_a_r || fill_a_r == FULL_CNT) begin
              // dropped push: report overflow once the output slot is free
              if (slot_free) begin
                out_valid_nxt  = 1'b1;
                out_word_nxt   = '0;
                out_status_nxt = ST_OVF;
                out_last_nxt   = !merge_go(a_nz, b_nz, closed_a_r, closed_b_r, fin_r);
                state_nxt      = out_last_nxt ? S_IDLE : S_READ;
              end
            end else begin
              we_a       = 1'b1;
              fill_a_nxt = fill_a_r + 1'b1;
              state_nxt  = merge_go(1'b1, b_nz, closed_a_r, closed_b_r, fin_r)
                           ? S_READ : S_IDLE;
            end
          end
          CMD_PUSH_B: begin
            if (closed_b_r || fill_b_r == FULL_CNT) begin
              if (slot_free) begin
                out_valid_nxt  = 1'b1;
                out_word_nxt   = '0;
                out_status_nxt = ST_OVF;
                out_last_nxt   = !merge_go(a_nz, b_nz, closed_a_r, closed_b_r, fin_r);
                state_nxt      = out_last_nxt ? S_IDLE : S_READ;
              end
            end else begin
              we_b       = 1'b1;
              fill_b_nxt = fill_b_r + 1'b1;
              state_nxt  = merge_go(a_nz, 1'b1, closed_a_r, closed_b_r, fin_r)
                           ? S_READ : S_IDLE;
            end
          end
          CMD_CLOSE_A: begin
            closed_a_nxt = 1'b1;
            state_nxt    = merge_go(a_nz, b_nz, 1'b1, closed_b_r, fin_r)
                           ? S_READ : S_IDLE;
          end
          default: begin
            closed_b_nxt = 1'b1;
            state_nxt    = merge_go(a_nz, b_nz, closed_a_r, 1'b1, fin_r)
                           ? S_READ : S_IDLE;
          end
        endcase
      end

      // head data from the rams arrives during the next state
      S_READ: begin
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (pop_a) begin
            out_word_nxt   = head_val_a;
            out_status_nxt = ST_ELEM;
            fill_a_nxt     = fill_a_r - 1'b1;
            head_a_nxt     = (head_a_r == LAST_IDX) ? '0 : head_a_r + 1'b1;
          end else if (pop_b) begin
            out_word_nxt   = head_val_b;
            out_status_nxt = ST_ELEM;
            fill_b_nxt     = fill_b_r - 1'b1;
            head_b_nxt     = (head_b_r == LAST_IDX) ? '0 : head_b_r + 1'b1;
          end else begin
            // both sides closed and empty: end marker
            out_word_nxt   = '0;
            out_status_nxt = ST_END;
            fin_nxt        = 1'b1;
          end
          out_last_nxt = !merge_go(fill_a_nxt != '0, fill_b_nxt != '0,
                                   closed_a_r, closed_b_r, fin_nxt);
          state_nxt    = out_last_nxt ? S_IDLE : S_READ;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_a_r    <= '0;
      fill_b_r    <= '0;
      head_a_r    <= '0;
      head_b_r    <= '0;
      closed_a_r  <= 1'b0;
      closed_b_r  <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_a_r    <= fill_a_nxt;
      fill_b_r    <= fill_b_nxt;
      head_a_r    <= head_a_nxt;
      head_b_r    <= head_b_nxt;
      closed_a_r  <= closed_a_nxt;
      closed_b_r  <= closed_b_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    word_r       <= word_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_merged_word = out_word_r;
  assign out_status      = out_status_r;
  assign out_run_last    = out_last_r;

  // fill counts never exceed the buffer depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_a_r <= FULL_CNT && fill_b_r <= FULL_CNT)
    else $error("fill count beyond buffer depth");

  // when idle the merge loop has nothing left to give
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !merge_go(a_nz, b_nz, closed_a_r, closed_b_r, fin_r))
    else $error("idle with merge work pending");

  // end marker only after both sides closed and drained
  a_fin_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (closed_a_r && closed_b_r && !a_nz && !b_nz))
    else $error("finished with open or non-empty side");

  // never pop an empty buffer
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && slot_free) |-> ((!pop_a || a_nz) && (!pop_b || b_nz)))
    else $error("pop from empty buffer");

  // a transfer that ends its run returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && slot_free && out_last_nxt) |=> state_r == S_IDLE)
    else $error("last result without return to idle");

endmodule
